/* src/mktd_pkg.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Shared constants, types and the letter lookup for the decoder block.
// ----------------------------------------------------------------------------
package mktd_pkg;

  // Sizes of the key time table and of the element store.
  localparam int KEY_COUNT    = 128;
  localparam int KEY_AW       = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int MAX_ELEMENTS = 8;
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);

  // Field widths of the ports.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 7;
  localparam int TIME_W   = 32;
  localparam int UNIT_W   = 16;
  localparam int LETTER_W = 7;
  localparam int BITS_W   = 8;
  localparam int COUNT_W  = 4;

  // Unit multiples: three units and six units of a 16-bit unit time.
  localparam int U3_W = UNIT_W + 2;
  localparam int U6_W = UNIT_W + 3;

  // Reset value of the unit time register, in milliseconds.
  localparam int UNIT_RESET = 80;

  // ASCII codes used for the result letter.
  localparam int ASCII_A     = 65;
  localparam int ASCII_SPACE = 32;

  // Item kinds.
  typedef enum logic [OP_W-1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Letters A to Z: element count in the high nibble, elements in the low
  // nibble with the oldest in bit 0 and a one for a dash.
  localparam logic [7:0] LETTER_CODES [26] = '{
    8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
    8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
    8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
  };

  // Write request into the key time table.
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [TIME_W-1:0] data;
  } key_wr_t;

  // One decoded character.
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic [BITS_W-1:0]   element_bits;
    logic [COUNT_W-1:0]  element_count;
    logic                too_long;
  } result_t;

  // Map an element pattern to its letter, or a space if it is none.
  function automatic logic [LETTER_W-1:0] lookup_letter(logic [3:0] bits,
                                                        logic [LEN_W-1:0] count);
    logic [LETTER_W-1:0] result;
    result = LETTER_W'(ASCII_SPACE);
    if (count inside {[1:4]}) begin
      for (int i = 0; i < 26; i++) begin
        if (LETTER_CODES[i][7:4] == 4'(count) && LETTER_CODES[i][3:0] == bits) begin
          result = LETTER_W'(ASCII_A + i);
        end
      end
    end
    return result;
  endfunction

endpackage

/* src/mktd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mktd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/mktd_key_store.sv */
// ----------------------------------------------------------------------------
// Key time store
// Per-key time of the last press or release, with reset valid bits and a
// bypass for a write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module mktd_key_store import mktd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [KEY_AW-1:0] rd_addr,
  input  key_wr_t           wr,
  output logic [TIME_W-1:0] rd_data
);

  logic [KEY_COUNT-1:0] key_valid;
  logic [TIME_W-1:0]    ram_q;
  logic                 rd_valid;
  logic                 byp_hit;
  logic [TIME_W-1:0]    byp_data;

  mktd_ram #(
    .WIDTH(TIME_W),
    .DEPTH(KEY_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Entries never written read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= '0;
    end else if (wr.en) begin
      key_valid[wr.addr] <= 1'b1;
    end
  end

  // Capture the valid bit and any same-edge write along with the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= key_valid[rd_addr];
      byp_hit  <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  assign rd_data = byp_hit  ? byp_data :
                   rd_valid ? ram_q    : '0;

endmodule

/* src/mktd_core.sv */
// ----------------------------------------------------------------------------
// Decoder core
// Timing state of the key and the pending character, updated once per
// transfer, and the result of a decoding tick.
// ----------------------------------------------------------------------------
module mktd_core import mktd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [OP_W-1:0]   op,
  input  logic [KEY_W-1:0]  key,
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] key_time,
  input  logic [U3_W-1:0]   unit3,
  input  logic [U6_W-1:0]   unit6,
  output logic              emit,
  output result_t           result,
  output key_wr_t           key_wr
);

  // Timing and character state.
  logic [TIME_W-1:0]       last_press_time, last_press_time_next;
  logic                    press_seen, press_seen_next;
  logic [TIME_W-1:0]       last_held, last_held_next;
  logic [MAX_ELEMENTS-1:0] pattern, pattern_next;
  logic [LEN_W-1:0]        pattern_len, pattern_len_next;
  logic                    overflow, overflow_next;
  logic                    decoded, decoded_next;

  logic                    is_press;
  logic                    is_release;
  logic                    is_tick;
  logic                    key_ok;
  logic [TIME_W-1:0]       gap;
  logic                    store_full;
  logic                    last_is_dash;
  logic [MAX_ELEMENTS-1:0] res_bits;
  logic [LEN_W-1:0]        res_count;

  assign is_press   = (op == OP_PRESS);
  assign is_release = (op == OP_RELEASE);
  assign is_tick    = (op == OP_TICK);
  assign key_ok     = ({1'b0, key} < (KEY_W + 1)'(KEY_COUNT));

  // Time since the last press, for both presses and ticks.
  assign gap        = now - last_press_time;
  assign store_full = (pattern_len >= LEN_W'(MAX_ELEMENTS));

  // The final element is a dash when it was held for 1.5 units or more.
  assign last_is_dash = ({last_held, 1'b0} >= (TIME_W + 1)'(unit3));

  // A tick decodes once, well after the last press.
  assign emit = is_tick && !decoded && press_seen && (gap > TIME_W'(unit6));

  // Result of a decoding tick: the pending elements plus the final one while the store has room.
  always_comb begin
    res_bits  = pattern;
    res_count = pattern_len;
    if (!store_full) begin
      if (last_is_dash) begin
        res_bits = pattern | (MAX_ELEMENTS'(1) << pattern_len);
      end
      res_count = pattern_len + LEN_W'(1);
    end
  end

  assign result.too_long      = overflow || store_full;
  assign result.letter        = result.too_long ? LETTER_W'(ASCII_SPACE) :
                                lookup_letter(4'(res_bits), res_count);
  assign result.element_bits  = BITS_W'(res_bits);
  assign result.element_count = COUNT_W'(res_count);

  // Every press or release of a known key stamps its time.
  assign key_wr.en   = fire && (is_press || is_release) && key_ok;
  assign key_wr.addr = key[KEY_AW-1:0];
  assign key_wr.data = now;

  // State update for one transfer.
  always_comb begin
    last_press_time_next = last_press_time;
    press_seen_next      = press_seen;
    last_held_next       = last_held;
    pattern_next         = pattern;
    pattern_len_next     = pattern_len;
    overflow_next        = overflow;
    decoded_next         = decoded;
    if (fire) begin
      if (is_press && key_ok) begin
        if (press_seen) begin
          if (gap >= TIME_W'(unit6)) begin
            pattern_next     = '0;
            pattern_len_next = '0;
            overflow_next    = 1'b0;
          end else if (!store_full) begin
            if (gap >= TIME_W'(unit3)) begin
              pattern_next = pattern | (MAX_ELEMENTS'(1) << pattern_len);
            end
            pattern_len_next = pattern_len + LEN_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
        end
        last_press_time_next = now;
        press_seen_next      = 1'b1;
        decoded_next         = 1'b0;
      end else if (is_release && key_ok) begin
        last_held_next = now - key_time;
        decoded_next   = 1'b0;
      end else if (emit) begin
        decoded_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_press_time <= '0;
      press_seen      <= 1'b0;
      last_held       <= '0;
      pattern         <= '0;
      pattern_len     <= '0;
      overflow        <= 1'b0;
      decoded         <= 1'b1;
    end else begin
      last_press_time <= last_press_time_next;
      press_seen      <= press_seen_next;
      last_held       <= last_held_next;
      pattern         <= pattern_next;
      pattern_len     <= pattern_len_next;
      overflow        <= overflow_next;
      decoded         <= decoded_next;
    end
  end

endmodule

/* src/morse_key_timing_decoder_top.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Turns timed key presses, releases and ticks into decoded letters.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle. An item is held in an input
// register while the per-key time table answers its read, and a decoding
// tick places its letter in the output register, so a result is offered in
// the cycle after its tick is transferred. The input stalls only while a new
// result is due and the output register still holds one that has not been
// taken. The key time table is a 128-entry RAM whose entries are cleared by
// valid bits at reset, so the block is ready right away.
module morse_key_timing_decoder_top import mktd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    key,
  input  logic [TIME_W-1:0]   time_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LETTER_W-1:0] letter,
  output logic [BITS_W-1:0]   element_bits,
  output logic [COUNT_W-1:0]  element_count,
  output logic                too_long,
  input  logic                cfg_we,
  input  logic [UNIT_W-1:0]   cfg_wdata
);

  logic [U3_W-1:0]   unit3;
  logic [U6_W-1:0]   unit6;
  logic [U3_W-1:0]   unit3_next;
  logic              accept;
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [KEY_W-1:0]  s1_key;
  logic [TIME_W-1:0] s1_time;
  logic              s1_done;
  logic              fire;
  logic              emit;
  logic [TIME_W-1:0] key_time;
  result_t           core_result;
  result_t           out_result;
  key_wr_t           key_wr;

  // Unit time register, kept as its three- and six-unit multiples.
  assign unit3_next = {2'b00, cfg_wdata} + {1'b0, cfg_wdata, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      unit3 <= U3_W'(3 * UNIT_RESET);
      unit6 <= U6_W'(6 * UNIT_RESET);
    end else if (cfg_we) begin
      unit3 <= unit3_next;
      unit6 <= {unit3_next, 1'b0};
    end
  end

  // Input stage handshake.
  assign s1_done  = s1_valid && (!emit || !out_valid || out_ready);
  assign fire     = s1_done;
  assign in_ready = !s1_valid || s1_done;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op;
      s1_key  <= key;
      s1_time <= time_ms;
    end
  end

  // Per-key time table, read as the item is transferred in.
  mktd_key_store u_key_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(key[KEY_AW-1:0]),
    .wr     (key_wr),
    .rd_data(key_time)
  );

  mktd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (s1_op),
    .key     (s1_key),
    .now     (s1_time),
    .key_time(key_time),
    .unit3   (unit3),
    .unit6   (unit6),
    .emit    (emit),
    .result  (core_result),
    .key_wr  (key_wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_result <= core_result;
    end
  end

  assign letter        = out_result.letter;
  assign element_bits  = out_result.element_bits;
  assign element_count = out_result.element_count;
  assign too_long      = out_result.too_long;

endmodule

/* sim/morse_letter_checker.sv */
// ----------------------------------------------------------------------------
// Morse letter checker
// Watches the item and letter channels of the Morse key timing decoder. It
// keeps its own copy of the key timing state, predicts the letter that each
// decoding tick must produce, and compares every letter transfer with the
// oldest prediction.
// ----------------------------------------------------------------------------
module morse_letter_checker import mktd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    key,
  input  logic [TIME_W-1:0]   time_ms,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [LETTER_W-1:0] letter,
  input  logic [BITS_W-1:0]   element_bits,
  input  logic [COUNT_W-1:0]  element_count,
  input  logic                too_long,
  input  logic                cfg_we,
  input  logic [UNIT_W-1:0]   cfg_wdata,
  output int                  error_count,
  output int                  letters_due
);

  // Predicted decoder state.
  logic [UNIT_W-1:0]       unit_ms;
  logic [TIME_W-1:0]       key_stamp [KEY_COUNT];
  logic [TIME_W-1:0]       press_stamp;
  logic                    had_press;
  logic [TIME_W-1:0]       held_ms;
  logic [MAX_ELEMENTS-1:0] pattern;
  int                      pattern_len;
  logic                    overflowed;
  logic                    decoded;

  // Letters predicted but not yet transferred, oldest first.
  result_t letter_queue [$];
  int      errors;

  // Letter for a pattern of one to four elements, a space for anything else.
  function automatic logic [LETTER_W-1:0] letter_for(logic [MAX_ELEMENTS-1:0] bits,
                                                     int count);
    logic [LETTER_W-1:0] ch;
    ch = LETTER_W'(ASCII_SPACE);
    if (count >= 1 && count <= 4) begin
      for (int i = 0; i < 26; i++) begin
        if (int'(LETTER_CODES[i][7:4]) == count && LETTER_CODES[i][3:0] == bits[3:0]) begin
          ch = LETTER_W'(ASCII_A + i);
        end
      end
    end
    return ch;
  endfunction

  // Advance the predicted state by one item; returns 1 when a letter is due.
  function automatic bit decode_item(logic [OP_W-1:0] kind, logic [KEY_W-1:0] k,
                                     logic [TIME_W-1:0] t, output result_t r);
    logic [TIME_W-1:0]       diff;
    logic [63:0]             gap;
    logic [63:0]             unit3;
    logic [63:0]             unit6;
    logic [MAX_ELEMENTS-1:0] bits;
    int                      count;
    logic                    over;
    r     = '0;
    diff  = t - press_stamp;
    gap   = 64'(diff);
    unit3 = 64'(unit_ms) * 3;
    unit6 = 64'(unit_ms) * 6;
    case (op_t'(kind))
      OP_PRESS, OP_RELEASE: begin
        // Keys outside the table are dropped without a trace.
        if (int'(k) >= KEY_COUNT) return 1'b0;
        if (op_t'(kind) == OP_PRESS) begin
          // The gap to the previous press closes that element or the character.
          if (had_press) begin
            if (gap >= unit6) begin
              pattern     = '0;
              pattern_len = 0;
              overflowed  = 1'b0;
            end else if (pattern_len < MAX_ELEMENTS) begin
              if (gap >= unit3) pattern[pattern_len] = 1'b1;
              pattern_len = pattern_len + 1;
            end else begin
              overflowed = 1'b1;
            end
          end
          press_stamp = t;
          had_press   = 1'b1;
        end else begin
          held_ms = t - key_stamp[k];
        end
        key_stamp[k] = t;
        decoded      = 1'b0;
        return 1'b0;
      end
      OP_TICK: begin
        // Decode once, only after six units of silence since the last press.
        if (decoded || !had_press) return 1'b0;
        if (gap <= unit6) return 1'b0;
        bits  = pattern;
        count = pattern_len;
        over  = overflowed;
        // The final element is judged from the last held duration.
        if (count < MAX_ELEMENTS) begin
          if (64'(held_ms) * 2 >= unit3) bits[count] = 1'b1;
          count = count + 1;
        end else begin
          over = 1'b1;
        end
        r.letter        = over ? LETTER_W'(ASCII_SPACE) : letter_for(bits, count);
        r.element_bits  = BITS_W'(bits);
        r.element_count = COUNT_W'(count);
        r.too_long      = over;
        decoded         = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Track configuration, predict on each item transfer and check each letter.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      unit_ms     = UNIT_W'(UNIT_RESET);
      press_stamp = '0;
      had_press   = 1'b0;
      held_ms     = '0;
      pattern     = '0;
      pattern_len = 0;
      overflowed  = 1'b0;
      decoded     = 1'b1;
      for (int i = 0; i < KEY_COUNT; i++) key_stamp[i] = '0;
      letter_queue.delete();
    end else begin
      if (cfg_we) unit_ms = cfg_wdata;
      if (out_valid && out_ready) begin
        got.letter        = letter;
        got.element_bits  = element_bits;
        got.element_count = element_count;
        got.too_long      = too_long;
        if (letter_queue.size() == 0) begin
          $display("%0t: letter transfer with none expected, got letter %0d bits %h",
                   $time, got.letter, got.element_bits);
          errors++;
        end else begin
          want = letter_queue.pop_front();
          if (got.letter !== want.letter) begin
            $display("%0t: letter expected %0d, got %0d", $time, want.letter, got.letter);
            errors++;
          end
          if (got.element_bits !== want.element_bits) begin
            $display("%0t: element_bits expected %h, got %h", $time,
                     want.element_bits, got.element_bits);
            errors++;
          end
          if (got.element_count !== want.element_count) begin
            $display("%0t: element_count expected %0d, got %0d", $time,
                     want.element_count, got.element_count);
            errors++;
          end
          if (got.too_long !== want.too_long) begin
            $display("%0t: too_long expected %0d, got %0d", $time,
                     want.too_long, got.too_long);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_item(op, key, time_ms, want)) letter_queue.push_back(want);
      end
    end
    error_count <= errors;
    letters_due <= letter_queue.size();
  end

endmodule

/* sim/morse_key_timing_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder testbench
// Drives timed key presses, releases and ticks into the decoder under several
// unit times, with random gaps and output stalls, and reports the verdict
// from the failure count of the letter checker.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_top_tb import mktd_pkg::*; ();

  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int PHASE_ITEMS   = 100;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     op_in;
  logic [KEY_W-1:0]    key;
  logic [TIME_W-1:0]   time_ms;
  logic                out_valid;
  logic                out_ready;
  logic [LETTER_W-1:0] letter;
  logic [BITS_W-1:0]   element_bits;
  logic [COUNT_W-1:0]  element_count;
  logic                too_long;
  logic                cfg_we;
  logic [UNIT_W-1:0]   cfg_wdata;

  int                  mismatches;
  int                  letters_due;
  int                  unit_ms;
  logic [TIME_W-1:0]   press_ms;
  logic                steady_in;
  int                  items_sent;
  int                  quiet_cycles;

  morse_key_timing_decoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op_in),
    .key           (key),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .letter        (letter),
    .element_bits  (element_bits),
    .element_count (element_count),
    .too_long      (too_long),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  morse_letter_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op_in),
    .key           (key),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .letter        (letter),
    .element_bits  (element_bits),
    .element_count (element_count),
    .too_long      (too_long),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .error_count   (mismatches),
    .letters_due   (letters_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Held time that reads as a dot (under 1.5 units) or a dash.
  function automatic logic [TIME_W-1:0] hold_span(logic dash, int u);
    if (dash) return TIME_W'($urandom_range((3 * u + 1) / 2, 6 * u));
    return TIME_W'($urandom_range(0, (3 * u - 1) / 2));
  endfunction

  // Press-to-press spacing that reads as a dot (under 3 units) or a dash.
  function automatic logic [TIME_W-1:0] press_spacing(logic dash, int u);
    if (dash) return TIME_W'($urandom_range(3 * u, 6 * u - 1));
    return TIME_W'($urandom_range(0, 3 * u - 1));
  endfunction

  // Offer one item after a random gap and hold it until it is transferred.
  task automatic send_item(op_t kind, logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
    int idle;
    idle = steady_in ? 0 : idle_cycles();
    if (idle > 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid = 1'b1;
    op_in    = kind;
    key      = k;
    time_ms  = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop offering items and wait until every letter is out and the pipe is empty.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (letters_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_unit(int u);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = UNIT_W'(u);
    @(negedge clk);
    cfg_we    = 1'b0;
    unit_ms   = u;
  endtask

  // One keyed character with random elements, closed by decoding ticks.
  task automatic key_character();
    int                u;
    int                r;
    int                len;
    logic [KEY_W-1:0]  k;
    logic [TIME_W-1:0] t;
    logic [15:0]       dashes;
    u = unit_ms;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 4);
    else if (r < 85) len = $urandom_range(5, 7);
    else len = $urandom_range(8, 11);
    dashes    = 16'($urandom);
    k         = KEY_W'($urandom);
    steady_in = ($urandom_range(0, 4) == 0);
    t = press_ms + TIME_W'(6 * u + $urandom_range(0, 2 * u));
    for (int i = 0; i < len; i++) begin
      send_item(OP_PRESS, k, t);
      press_ms = t;
      // Now and then the release comes from another key.
      send_item(OP_RELEASE, ($urandom_range(0, 11) == 0) ? KEY_W'($urandom) : k,
                t + hold_span(dashes[i], u));
      // An early tick must not decode anything.
      if ($urandom_range(0, 7) == 0)
        send_item(OP_TICK, KEY_W'($urandom), t + TIME_W'($urandom_range(0, 6 * u)));
      t = t + press_spacing(dashes[i], u);
    end
    if ($urandom_range(0, 2) == 0) send_item(OP_TICK, k, press_ms + TIME_W'(6 * u));
    send_item(OP_TICK, k, press_ms + TIME_W'(6 * u + 1 + $urandom_range(0, u)));
    // A second late tick finds the character already decoded.
    if ($urandom_range(0, 3) == 0)
      send_item(OP_TICK, k, press_ms + TIME_W'(7 * u + $urandom_range(0, 4 * u)));
  endtask

  // Stray items of any kind, key and time.
  task automatic stray_items();
    repeat ($urandom_range(1, 3)) begin
      send_item(op_t'($urandom_range(0, 3)), KEY_W'($urandom),
                ($urandom_range(0, 1) == 0) ? TIME_W'($urandom)
                                            : press_ms + TIME_W'($urandom_range(0, 8 * unit_ms)));
    end
  endtask

  // Output side: runs of ready broken by stalls of random length.
  initial begin : ready_pattern
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      hold = $urandom_range(1, 40);
      repeat (hold - 1) @(negedge clk);
      hold = idle_cycles();
      if (hold > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // End the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("morse_key_timing_decoder_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int units [7];
    int phase_end;
    units        = '{1, 65535, UNIT_RESET, 3, 2, 0, 0};
    units[5]     = $urandom_range(4, 65534);
    units[6]     = $urandom_range(5, 300);
    rst          = 1'b1;
    in_valid     = 1'b0;
    op_in        = OP_NONE;
    key          = '0;
    time_ms      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    unit_ms      = UNIT_RESET;
    press_ms     = '0;
    steady_in    = 1'b0;
    items_sent   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset unit time of 80 ms.
    // A tick with no press yet and an unknown kind both give nothing.
    send_item(OP_TICK, '0, 32'd1000);
    send_item(OP_NONE, 7'd127, 32'hFFFF_FFFF);
    // A press with no release yet decodes as a dot; the tick on six units
    // exactly does not decode, one past it does, and a repeat is silent.
    send_item(OP_PRESS, 7'd0, 32'd0);
    send_item(OP_TICK, 7'd0, 32'd480);
    send_item(OP_TICK, 7'd0, 32'd481);
    send_item(OP_TICK, 7'd0, 32'd600);
    // A full-range held time must read as a dash.
    send_item(OP_RELEASE, 7'd127, 32'hFFFF_FFFF);
    send_item(OP_PRESS, 7'd127, 32'd5000);
    send_item(OP_TICK, 7'd127, 32'd5481);
    // Dash then dot across the wrap of the millisecond counter.
    send_item(OP_PRESS, 7'd3, 32'hFFFF_FF00);
    send_item(OP_RELEASE, 7'd3, 32'h0000_0010);
    send_item(OP_PRESS, 7'd3, 32'h0000_0040);
    send_item(OP_RELEASE, 7'd3, 32'h0000_0050);
    send_item(OP_TICK, 7'd3, 32'h0000_0040 + 32'd481);
    press_ms = 32'h0000_0040;

    // Random characters under each unit time, extremes first.
    foreach (units[p]) begin
      set_unit(units[p]);
      press_ms  = TIME_W'($urandom);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) stray_items();
        if ($urandom_range(0, 19) == 0) press_ms = TIME_W'($urandom);
        key_character();
      end
    end

    steady_in = 1'b0;
    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("morse_key_timing_decoder_top_tb: done, clean");
    end else begin
      $display("morse_key_timing_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
